FILE: rtl/srsps_pkg.sv
// ----------------------------------------------------------------------------
// srsps_pkg: shared types and constants for the spaced point selector
// Field widths, input word kinds, register indexes, datapath command and status structs.
// ----------------------------------------------------------------------------
package srsps_pkg;

  localparam int unsigned MaxCandidates = 1024;
  localparam int unsigned MaxExisting   = 256;
  localparam int unsigned MaxKept       = 64;

  localparam int unsigned PosW   = 16;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned DepthW = 24;
  localparam int unsigned SpaceW = 12;
  localparam int unsigned MaxPtW = 6;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned DistW  = 34;

  localparam logic [SpaceW-1:0] SpacingReset = 12'd40;
  localparam logic [MaxPtW-1:0] MaxPtsReset  = 6'd63;

  typedef enum logic [1:0] {
    KindExist = 2'd0,
    KindCand  = 2'd1,
    KindRun   = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic {
    RegSpacing = 1'b0,
    RegMaxPts  = 1'b1
  } reg_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load_exist;
    logic load_cand;
    logic scan_start;   // reset best-search, begin at candidate 0
    logic scan_step;    // compare current candidate, advance
    logic mark_best;    // set visited bit of best
    logic chk_start;    // begin distance checks on best
    logic chk_step;     // step the distance check, advance over stored points
    logic keep_best;    // append best to kept store
    logic emit_start;
    logic emit_step;
    logic clear;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_done;    // all candidates looked at
    logic found;        // an unvisited candidate exists
    logic chk_done;     // all existing and kept points checked, or one too close
    logic too_close;    // a stored point lies inside the spacing
    logic stop_walk;    // limit reached after the latest keep
    logic emit_done;
    logic none_kept;
  } dp_sts_t;

endpackage

FILE: rtl/srsps_datapath.sv
// ----------------------------------------------------------------------------
// srsps_datapath: point stores, best-score scan and distance check
// Candidate, existing and kept stores as memories; one scan compare per cycle.
// ----------------------------------------------------------------------------
module srsps_datapath import srsps_pkg::*; #(
  parameter int unsigned MAX_CANDIDATES = MaxCandidates,
  parameter int unsigned MAX_EXISTING   = MaxExisting,
  parameter int unsigned MAX_KEPT       = MaxKept
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [PosW-1:0]   pos_x_i,
  input  logic [PosW-1:0]   pos_y_i,
  input  logic [ScoreW-1:0] score_i,
  input  logic [DepthW-1:0] depth_i,
  input  logic [SpaceW-1:0] min_spacing_i,
  input  logic [MaxPtW-1:0] max_points_i,
  output logic [PosW-1:0]   sel_x_o,
  output logic [PosW-1:0]   sel_y_o,
  output logic [DepthW-1:0] sel_depth_o,
  output logic              last_o,
  output logic              emit_valid_o
);

  localparam int unsigned CIdxW = $clog2(MAX_CANDIDATES);
  localparam int unsigned CCntW = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned EIdxW = (MAX_EXISTING > 1) ? $clog2(MAX_EXISTING) : 1;
  localparam int unsigned ECntW = $clog2(MAX_EXISTING + 1);
  localparam int unsigned KIdxW = $clog2(MAX_KEPT);
  localparam int unsigned KCntW = $clog2(MAX_KEPT + 1);
  localparam int unsigned CandW = 2 * PosW + ScoreW + DepthW;
  localparam int unsigned PtW   = 2 * PosW;
  localparam int unsigned KeptW = 2 * PosW + DepthW;
  localparam int unsigned SumW  = (ECntW > KCntW ? ECntW : KCntW) + 1;

  logic [CandW-1:0] cand_mem [MAX_CANDIDATES];
  logic [PtW-1:0]   exist_mem [MAX_EXISTING];
  logic [KeptW-1:0] kept_mem [MAX_KEPT];
  // visited bits: one per entry, cleared by the run's end
  logic [MAX_CANDIDATES-1:0] visited_q;

  logic [CCntW-1:0] cand_cnt_q;
  logic [ECntW-1:0] exist_cnt_q;
  logic [KCntW-1:0] kept_cnt_q;

  logic [CCntW-1:0] scan_idx_q;
  logic             scan_rd_q;     // cand_rd_q holds entry scan_idx_q-1
  logic [CIdxW-1:0] rd_idx_q;
  logic [CandW-1:0] cand_rd_q;
  logic             rd_vis_q;
  logic             found_q;
  logic [CIdxW-1:0] best_idx_q;
  logic [ScoreW-1:0] best_score_q;
  logic [CandW-1:0] best_rec_q;

  // distance check: phase 0 existing, phase 1 kept; read then compare
  logic [ECntW-1:0] chk_e_q;
  logic [KCntW-1:0] chk_k_q;
  logic             chk_k_phase_q;
  logic             chk_rd_q;
  logic [PtW-1:0]   pt_rd_q;
  logic             close_q;
  logic [DistW-1:0] lim_q;
  logic [KCntW-1:0] emit_idx_q;
  logic [KeptW-1:0] kept_rd_q;
  logic             emit_v_q;
  logic             emit_last_q;

  // candidate memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cand && cand_cnt_q < CCntW'(MAX_CANDIDATES)) begin
      cand_mem[cand_cnt_q[CIdxW-1:0]] <= {pos_x_i, pos_y_i, score_i, depth_i};
    end
    cand_rd_q <= cand_mem[scan_idx_q[CIdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_exist && exist_cnt_q < ECntW'(MAX_EXISTING)) begin
      exist_mem[exist_cnt_q[EIdxW-1:0]] <= {pos_x_i, pos_y_i};
    end
    pt_rd_q <= exist_mem[chk_e_q[EIdxW-1:0]];
  end

  logic [KIdxW-1:0] kept_ra;
  logic [PtW-1:0]   kept_pt;
  assign kept_ra = cmd_i.emit_start ? '0 :
                   (cmd_i.emit_step || emit_v_q) ? emit_idx_q[KIdxW-1:0]
                                                  : chk_k_q[KIdxW-1:0];
  always_ff @(posedge clk_i) begin
    if (cmd_i.keep_best) begin
      kept_mem[kept_cnt_q[KIdxW-1:0]] <= {best_rec_q[CandW-1 -: PtW],
                                          best_rec_q[DepthW-1:0]};
    end
    kept_rd_q <= kept_mem[kept_ra];
  end
  assign kept_pt = kept_rd_q[KeptW-1 -: PtW];

  // squared distance of best to the point just read
  logic [PosW-1:0]  bx, by, px, py, dx, dy;
  logic [DistW-1:0] d2;
  assign bx = best_rec_q[CandW-1 -: PosW];
  assign by = best_rec_q[CandW-PosW-1 -: PosW];
  assign px = chk_k_phase_q ? kept_pt[PtW-1 -: PosW] : pt_rd_q[PtW-1 -: PosW];
  assign py = chk_k_phase_q ? kept_pt[PosW-1:0]      : pt_rd_q[PosW-1:0];
  assign dx = (bx > px) ? bx - px : px - bx;
  assign dy = (by > py) ? by - py : py - by;
  logic [2*PosW-1:0] dx2_q, dy2_q;
  logic              sq_v_q;
  assign d2 = DistW'(dx2_q) + DistW'(dy2_q);

  logic [SpaceW+3:0] sp16;
  assign sp16 = {min_spacing_i, 4'b0};

  logic e_left, k_left;
  assign e_left = chk_e_q < exist_cnt_q;
  assign k_left = chk_k_q < kept_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q     <= '0;
      cand_cnt_q    <= '0;
      exist_cnt_q   <= '0;
      kept_cnt_q    <= '0;
      scan_idx_q    <= '0;
      scan_rd_q     <= 1'b0;
      rd_idx_q      <= '0;
      rd_vis_q      <= 1'b0;
      found_q       <= 1'b0;
      best_idx_q    <= '0;
      best_score_q  <= '0;
      best_rec_q    <= '0;
      lim_q         <= '0;
      chk_e_q       <= '0;
      chk_k_q       <= '0;
      chk_k_phase_q <= 1'b0;
      chk_rd_q      <= 1'b0;
      sq_v_q        <= 1'b0;
      dx2_q         <= '0;
      dy2_q         <= '0;
      close_q       <= 1'b0;
      emit_idx_q    <= '0;
      emit_v_q      <= 1'b0;
      emit_last_q   <= 1'b0;
    end else begin
      emit_v_q <= 1'b0;
      if (cmd_i.load_exist && exist_cnt_q < ECntW'(MAX_EXISTING)) begin
        exist_cnt_q <= exist_cnt_q + 1'b1;
      end
      if (cmd_i.load_cand && cand_cnt_q < CCntW'(MAX_CANDIDATES)) begin
        cand_cnt_q <= cand_cnt_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        scan_rd_q  <= 1'b0;
        found_q    <= 1'b0;
      end else if (cmd_i.scan_step) begin
        // issue read of scan_idx_q, compare the entry read last cycle
        if (scan_idx_q < cand_cnt_q) begin
          scan_idx_q <= scan_idx_q + 1'b1;
          rd_idx_q   <= scan_idx_q[CIdxW-1:0];
          rd_vis_q   <= visited_q[scan_idx_q[CIdxW-1:0]];
          scan_rd_q  <= 1'b1;
        end else begin
          scan_rd_q <= 1'b0;
        end
        if (scan_rd_q && !rd_vis_q &&
            (!found_q || cand_rd_q[DepthW +: ScoreW] > best_score_q)) begin
          found_q      <= 1'b1;
          best_idx_q   <= rd_idx_q;
          best_score_q <= cand_rd_q[DepthW +: ScoreW];
          best_rec_q   <= cand_rd_q;
        end
      end
      if (cmd_i.mark_best) begin
        visited_q[best_idx_q] <= 1'b1;
      end
      if (cmd_i.chk_start) begin
        lim_q         <= DistW'(sp16) * DistW'(sp16);
        chk_e_q       <= '0;
        chk_k_q       <= '0;
        chk_k_phase_q <= 1'b0;
        chk_rd_q      <= 1'b0;
        sq_v_q        <= 1'b0;
        close_q       <= 1'b0;
      end else if (cmd_i.chk_step) begin
        // stage 1: address, stage 2: read data, stage 3: squares, then sum
        chk_rd_q <= 1'b0;
        if (!chk_rd_q && !sq_v_q) begin
          if (!chk_k_phase_q && e_left) begin
            chk_rd_q <= 1'b1;
          end else if (!chk_k_phase_q) begin
            chk_k_phase_q <= 1'b1;
          end else if (k_left) begin
            chk_rd_q <= 1'b1;
          end
        end
        sq_v_q <= chk_rd_q;
        if (chk_rd_q) begin
          dx2_q <= dx * dx;
          dy2_q <= dy * dy;
        end
        if (sq_v_q) begin
          if (d2 < lim_q) close_q <= 1'b1;
          if (!chk_k_phase_q) chk_e_q <= chk_e_q + 1'b1;
          else                chk_k_q <= chk_k_q + 1'b1;
        end
      end
      if (cmd_i.keep_best) begin
        kept_cnt_q <= kept_cnt_q + 1'b1;
      end
      if (cmd_i.emit_start) begin
        emit_idx_q <= KCntW'(1);
        emit_v_q   <= 1'b1;
        emit_last_q <= (kept_cnt_q == KCntW'(1));
      end else if (cmd_i.emit_step) begin
        emit_idx_q  <= emit_idx_q + 1'b1;
        emit_v_q    <= 1'b1;
        emit_last_q <= (emit_idx_q + 1'b1 == kept_cnt_q);
      end
      if (cmd_i.clear) begin
        visited_q   <= '0;
        cand_cnt_q  <= '0;
        exist_cnt_q <= '0;
        kept_cnt_q  <= '0;
      end
    end
  end

  logic [SumW-1:0] total;
  assign total = SumW'(kept_cnt_q) + SumW'(exist_cnt_q);

  assign sts_o.scan_done  = !scan_rd_q && (scan_idx_q >= cand_cnt_q);
  assign sts_o.found      = found_q;
  assign sts_o.chk_done   = close_q ||
                            (chk_k_phase_q && !k_left && !chk_rd_q && !sq_v_q);
  assign sts_o.too_close  = close_q;
  assign sts_o.stop_walk  = (total > SumW'(max_points_i)) ||
                            (kept_cnt_q >= KCntW'(MAX_KEPT));
  assign sts_o.emit_done  = (emit_idx_q >= kept_cnt_q);
  assign sts_o.none_kept  = (kept_cnt_q == '0);

  assign sel_x_o      = kept_rd_q[KeptW-1 -: PosW];
  assign sel_y_o      = kept_rd_q[KeptW-PosW-1 -: PosW];
  assign sel_depth_o  = kept_rd_q[DepthW-1:0];
  assign last_o       = emit_last_q;
  assign emit_valid_o = emit_v_q;

  ap_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_cnt_q <= KCntW'(MAX_KEPT))
    else $error("kept count over capacity");
  ap_keep_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.keep_best |-> !close_q)
    else $error("kept a point inside the spacing");
  ap_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> cand_cnt_q == '0 && visited_q == '0)
    else $error("stores not cleared");

endmodule

FILE: rtl/srsps_ctrl.sv
// ----------------------------------------------------------------------------
// srsps_ctrl: run sequencer
// Scans for the best candidate, checks spacing, keeps, then emits the words.
// ----------------------------------------------------------------------------
module srsps_ctrl import srsps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] kind_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    StIdle, StScan, StPick, StCheck, StDecide, StLimit, StEmit, StClear
  } state_e;

  state_e state_q;
  logic   accept;
  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.load_exist = accept && kind_i == KindExist;
    cmd_o.load_cand  = accept && kind_i == KindCand;
    cmd_o.scan_start = accept && kind_i == KindRun;
    case (state_q)
      StScan:   cmd_o.scan_step = 1'b1;
      StPick:   begin
        cmd_o.mark_best  = sts_i.found;
        cmd_o.chk_start  = sts_i.found;
        cmd_o.emit_start = !sts_i.found && !sts_i.none_kept;
      end
      StCheck:  cmd_o.chk_step = 1'b1;
      StDecide: begin
        cmd_o.keep_best  = !sts_i.too_close;
      end
      StLimit:  begin
        // stop test sees the count including this keep
        cmd_o.scan_start = !sts_i.stop_walk;
        cmd_o.emit_start = sts_i.stop_walk && !sts_i.none_kept;
      end
      StEmit:   cmd_o.emit_step = !sts_i.emit_done;
      StClear:  cmd_o.clear = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: if (accept && kind_i == KindRun) state_q <= StScan;
        StScan: if (sts_i.scan_done) state_q <= StPick;
        StPick: begin
          if (sts_i.found)          state_q <= StCheck;
          else if (sts_i.none_kept) state_q <= StClear;
          else                      state_q <= StEmit;
        end
        StCheck: if (sts_i.chk_done) state_q <= StDecide;
        StDecide: state_q <= StLimit;
        StLimit: begin
          if (!sts_i.stop_walk)     state_q <= StScan;
          else if (sts_i.none_kept) state_q <= StClear;
          else                      state_q <= StEmit;
        end
        StEmit: if (sts_i.emit_done) state_q <= StClear;
        StClear: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);

  ap_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KindRun) |=> busy_o)
    else $error("run not started");
  ap_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cmd_o.load_cand && !cmd_o.load_exist)
    else $error("load during run");
  ap_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> !busy_o)
    else $error("clear not followed by idle");

endmodule

FILE: rtl/score_ranked_spaced_point_select_unit.sv
// ----------------------------------------------------------------------------
// score_ranked_spaced_point_select_unit: greedy spacing point selector
// Load words are taken one per cycle while not busy, back to back. A run word
// holds busy; each visit scans the candidates, picks the best unvisited one,
// checks its spacing to existing and kept points, keeps it if clear and tests
// the limit; the run then emits the kept words and clears the stores. Results
// cannot be stalled. Reset empties all stores and loads register defaults;
// store contents are undefined until written.
// ----------------------------------------------------------------------------
module score_ranked_spaced_point_select_unit import srsps_pkg::*; #(
  parameter int unsigned MAX_CANDIDATES = MaxCandidates,
  parameter int unsigned MAX_EXISTING   = MaxExisting,
  parameter int unsigned MAX_KEPT       = MaxKept
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [PosW-1:0]   pos_x_i,
  input  logic [PosW-1:0]   pos_y_i,
  input  logic [ScoreW-1:0] score_i,
  input  logic [DepthW-1:0] depth_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  output logic              sel_valid_o,
  output logic [PosW-1:0]   sel_x_o,
  output logic [PosW-1:0]   sel_y_o,
  output logic [DepthW-1:0] sel_depth_o,
  output logic              last_o
);

  logic [SpaceW-1:0] min_spacing_q;
  logic [MaxPtW-1:0] max_points_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_spacing_q <= SpacingReset;
      max_points_q  <= MaxPtsReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegSpacing) min_spacing_q <= cfg_data_i[SpaceW-1:0];
      else                         max_points_q  <= cfg_data_i[MaxPtW-1:0];
    end
  end

  srsps_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .kind_i, .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy)
  );

  srsps_datapath #(
    .MAX_CANDIDATES(MAX_CANDIDATES), .MAX_EXISTING(MAX_EXISTING),
    .MAX_KEPT(MAX_KEPT)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .pos_x_i, .pos_y_i, .score_i,
    .depth_i, .min_spacing_i(min_spacing_q), .max_points_i(max_points_q),
    .sel_x_o, .sel_y_o, .sel_depth_o, .last_o, .emit_valid_o(sel_valid_o)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: spaced point selector check
// Loads existing and candidate points, runs greedy spacing selection and
// compares every emitted word against an in-bench predictor, over directed
// corner cases, a full kept store and randomized phases under changing settings.
// ----------------------------------------------------------------------------
module testbench;
  import srsps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_e             kind;
    logic [PosW-1:0]   x;
    logic [PosW-1:0]   y;
    logic [ScoreW-1:0] score;
    logic [DepthW-1:0] depth;
  } load_word_t;

  typedef struct {
    logic [PosW-1:0]   x;
    logic [PosW-1:0]   y;
    logic [DepthW-1:0] depth;
    logic              last;
  } sel_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start;
  logic              busy;
  logic [1:0]        kind_i;
  logic [PosW-1:0]   pos_x_i, pos_y_i;
  logic [ScoreW-1:0] score_i;
  logic [DepthW-1:0] depth_i;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [CfgW-1:0]   cfg_data_i;
  logic              sel_valid_o;
  logic [PosW-1:0]   sel_x_o, sel_y_o;
  logic [DepthW-1:0] sel_depth_o;
  logic              last_o;

  score_ranked_spaced_point_select_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [PosW-1:0]   cand_x[MaxCandidates], cand_y[MaxCandidates];
  logic [ScoreW-1:0] cand_sc[MaxCandidates];
  logic [DepthW-1:0] cand_dp[MaxCandidates];
  int unsigned       n_cand;
  logic [PosW-1:0]   ex_x[MaxExisting], ex_y[MaxExisting];
  int unsigned       n_exist;
  logic [SpaceW-1:0] spacing = SpacingReset;
  logic [MaxPtW-1:0] max_pts = MaxPtsReset;

  sel_word_t sel_expected[$];
  int        errors;
  bit        gaps_on = 1'b1;

  function automatic bit near(logic [PosW-1:0] ax, logic [PosW-1:0] ay,
                              logic [PosW-1:0] bx, logic [PosW-1:0] by,
                              longint unsigned lim);
    longint unsigned dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return dx * dx + dy * dy < lim;
  endfunction

  function automatic void select_points();
    bit              seen[MaxCandidates];
    sel_word_t       kept[$];
    sel_word_t       s;
    longint unsigned lim;
    int              best;
    bit              keep;
    lim = longint'(spacing) * 16 * longint'(spacing) * 16;
    for (int v = 0; v < n_cand; v++) begin
      best = -1;
      for (int i = 0; i < n_cand; i++)
        if (!seen[i] && (best < 0 || cand_sc[i] > cand_sc[best])) best = i;
      if (best < 0) break;
      seen[best] = 1'b1;
      keep = 1'b1;
      for (int k = 0; k < n_exist && keep; k++)
        if (near(cand_x[best], cand_y[best], ex_x[k], ex_y[k], lim)) keep = 1'b0;
      foreach (kept[k])
        if (keep && near(cand_x[best], cand_y[best], kept[k].x, kept[k].y, lim))
          keep = 1'b0;
      if (keep) begin
        s.x = cand_x[best];
        s.y = cand_y[best];
        s.depth = cand_dp[best];
        s.last = 1'b0;
        kept = {kept, s};
      end
      if (kept.size() + n_exist > max_pts || kept.size() >= MaxKept) break;
    end
    foreach (kept[k]) begin
      kept[k].last = (k == kept.size() - 1);
      sel_expected = {sel_expected, kept[k]};
    end
    n_cand = 0;
    n_exist = 0;
  endfunction

  function automatic void predict(load_word_t w);
    case (w.kind)
      KindExist: if (n_exist < MaxExisting) begin
        ex_x[n_exist] = w.x;
        ex_y[n_exist] = w.y;
        n_exist++;
      end
      KindCand: if (n_cand < MaxCandidates) begin
        cand_x[n_cand] = w.x;
        cand_y[n_cand] = w.y;
        cand_sc[n_cand] = w.score;
        cand_dp[n_cand] = w.depth;
        n_cand++;
      end
      KindRun: select_points();
      default: ;
    endcase
  endfunction

  task automatic send_word(input load_word_t w);
    if (gaps_on && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start   <= 1'b1;
    kind_i  <= w.kind;
    pos_x_i <= w.x;
    pos_y_i <= w.y;
    score_i <= w.score;
    depth_i <= w.depth;
    do @(posedge clk_i); while (busy);
    predict(w);
  endtask

  task automatic send(input kind_e kind, input int x, input int y,
                      input int sc = 0, input int dp = 0);
    load_word_t w;
    w.kind = kind;
    w.x = PosW'(x);
    w.y = PosW'(y);
    w.score = ScoreW'(sc);
    w.depth = DepthW'(dp);
    send_word(w);
  endtask

  // hold until all selections have come out and the unit is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sel_expected.size() != 0 || busy);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input int value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegSpacing) spacing = SpaceW'(value);
    else max_pts = MaxPtW'(value);
  endtask

  always @(posedge clk_i) begin
    sel_word_t e;
    if (rst_ni && sel_valid_o) begin
      if (sel_expected.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h depth=%h last=%b", $time,
                 sel_x_o, sel_y_o, sel_depth_o, last_o);
        errors++;
      end else begin
        e = sel_expected.pop_front();
        if (e.x !== sel_x_o || e.y !== sel_y_o || e.depth !== sel_depth_o ||
            e.last !== last_o) begin
          $display("%0t: expected x=%h y=%h depth=%h last=%b, got x=%h y=%h depth=%h last=%b",
                   $time, e.x, e.y, e.depth, e.last,
                   sel_x_o, sel_y_o, sel_depth_o, last_o);
          errors++;
        end
      end
    end
  end

  // corners at reset settings: field extremes, score ties, ignored kind,
  // run with junk fields, empty run
  task automatic test_corners();
    send(KindExist, 16'h0000, 16'h0000, 16'hFFFF, 24'hFFFFFF);
    send(KindCand, 16'h0100, 16'h0100, 16'h8000, 24'h000001);
    send(KindCand, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send(KindCand, 16'hFFFF, 16'h0000, 16'h0000, 24'h000000);
    send(KindCand, 16'h0000, 16'hFFFF, 16'h0000, 24'hABCDEF);
    send(KindCand, 16'h8000, 16'h8000, 16'h1234, 24'h123456);
    send(KindCand, 16'h8010, 16'h8000, 16'h1234, 24'h654321);
    send(KindNone, 16'h1111, 16'h2222, 16'hFFFF, 24'hFFFFFF);
    send(KindRun, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send(KindRun, 16'h0000, 16'h0000, 16'h0000, 24'h000000);
    send(KindExist, 16'h0500, 16'h0500);
    send(KindCand, 16'h0510, 16'h0500, 16'h0100, 24'h000010);
    send(KindRun, 0, 0);
  endtask

  // spacing zero rejects nothing: kept store fills; widest spacing rejects points nearer than 65520
  task automatic test_spacing_extremes();
    write_reg(RegSpacing, 0);
    for (int i = 0; i < 70; i++)
      send(KindCand, $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 7), $urandom);
    send(KindRun, 0, 0);
    write_reg(RegSpacing, 4095);
    for (int i = 0; i < 6; i++)
      send(KindCand, $urandom, $urandom, $urandom_range(0, 3), $urandom);
    send(KindRun, 0, 0);
  endtask

  // existing count already past the limit: first candidate still visited
  task automatic test_over_limit();
    write_reg(RegMaxPts, 0);
    write_reg(RegSpacing, 1);
    send(KindExist, 16'h4000, 16'h4000);
    send(KindExist, 16'h6000, 16'h6000);
    send(KindCand, 16'h1000, 16'h1000, 16'h0010, 24'h000777);
    send(KindCand, 16'h2000, 16'h2000, 16'h0020, 24'h000888);
    send(KindRun, 0, 0);
  endtask

  task automatic test_random();
    int base_x, base_y, n_e, n_c, sent;
    sent = 0;
    for (int ph = 0; sent < 110; ph++) begin
      gaps_on = (ph % 5 != 2);
      if (ph % 3 == 0) begin
        write_reg(RegSpacing, ($urandom_range(9) == 0) ? 4095 : $urandom_range(0, 60));
        write_reg(RegMaxPts, ($urandom_range(4) == 0) ? 63 : $urandom_range(0, 20));
      end
      base_x = $urandom_range(0, 60000);
      base_y = $urandom_range(0, 60000);
      n_e = $urandom_range(0, 4);
      n_c = $urandom_range(1, 16);
      for (int i = 0; i < n_e + n_c; i++) begin
        if ($urandom_range(19) == 0) send(KindNone, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(7) == 0)
          send(i < n_e ? KindExist : KindCand, $urandom, $urandom, $urandom, $urandom);
        else
          send(i < n_e ? KindExist : KindCand,
               base_x + $urandom_range(0, 4000), base_y + $urandom_range(0, 4000),
               $urandom_range(0, 6) << 8, $urandom);
        sent++;
      end
      send(KindRun, $urandom, $urandom, $urandom, $urandom);
      sent++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    start      <= 1'b0;
    kind_i     <= KindNone;
    pos_x_i    <= '0;
    pos_y_i    <= '0;
    score_i    <= '0;
    depth_i    <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= RegSpacing;
    cfg_data_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_spacing_extremes();
    test_over_limit();
    test_random();
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/srsps_pkg.sv
rtl/srsps_datapath.sv
rtl/srsps_ctrl.sv
rtl/score_ranked_spaced_point_select_unit.sv
tb/testbench.sv
